// ----- hdl/vwce_pkg.sv -----
// Package with the shared types, constants and helper functions of the window editor.
`default_nettype none

package vwce_pkg;

  localparam int BTN_W = 10;
  localparam int COORD_W = 12;
  localparam int MATTE_W = 11;
  localparam int CANVAS_W = 12;
  localparam int CFG_ADDR_W = 4;
  localparam int WIDE_W = 15;

  localparam int BTN_RIGHT = 0;
  localparam int BTN_LEFT = 1;
  localparam int BTN_DOWN = 2;
  localparam int BTN_UP = 3;
  localparam int BTN_MOVE = 4;
  localparam int BTN_INNER = 5;
  localparam int BTN_OUTER = 6;
  localparam int BTN_ACCEPT = 7;
  localparam int BTN_CANCEL = 8;
  localparam int BTN_RESET = 9;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_BEGIN = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_CANVAS_WIDTH = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CANVAS_HEIGHT = 4'd1;

  localparam logic [CANVAS_W-1:0] CANVAS_W_RESET = 12'd720;
  localparam logic [CANVAS_W-1:0] CANVAS_H_RESET = 12'd480;
  localparam logic [CANVAS_W-1:0] MIN_CANVAS = 12'd16;
  localparam logic [CANVAS_W-1:0] MAX_CANVAS = 12'd4095;
  localparam logic [COORD_W-1:0] MIN_SIZE = 12'd16;
  localparam logic signed [WIDE_W-1:0] MIN_SIZE_S = 15'sd16;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_EDIT = 2'd1,
    MODE_REVIEW = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_ACCEPTED = 2'd1,
    EV_CANCELLED = 2'd2,
    EV_RELEASED = 2'd3
  } event_t;

  typedef struct packed {
    logic [COORD_W-1:0] win_x;
    logic [COORD_W-1:0] win_y;
    logic [COORD_W-1:0] win_width;
    logic [COORD_W-1:0] win_height;
    logic [MATTE_W-1:0] inner_x;
    logic [MATTE_W-1:0] inner_y;
    logic [COORD_W-1:0] outer_x;
    logic [COORD_W-1:0] outer_y;
  } region_t;

  typedef struct packed {
    logic op;
    logic [BTN_W-1:0] held_buttons;
    logic [BTN_W-1:0] new_presses;
  } in_item_t;

  typedef struct packed {
    logic ok;
    event_t event_res;
    mode_t mode;
    logic owns_foreground;
    region_t region;
  } out_item_t;

  function automatic region_t default_region(input logic [CANVAS_W-1:0] cw,
                                             input logic [CANVAS_W-1:0] ch);
    region_t r;
    logic [COORD_W-1:0] dw;
    logic [COORD_W-1:0] dh;
    dw = {1'b0, cw[11:5], 4'b0000};
    dh = {1'b0, ch[11:5], 4'b0000};
    if (dw < MIN_SIZE) dw = MIN_SIZE;
    if (dh < MIN_SIZE) dh = MIN_SIZE;
    r.win_width = dw;
    r.win_height = dh;
    r.win_x = (cw - dw) >> 1;
    r.win_y = (ch - dh) >> 1;
    r.inner_x = '0;
    r.inner_y = '0;
    r.outer_x = '0;
    r.outer_y = '0;
    return r;
  endfunction

  function automatic logic region_ok(input region_t r,
                                     input logic [CANVAS_W-1:0] cw,
                                     input logic [CANVAS_W-1:0] ch);
    logic good;
    good = (r.win_width >= MIN_SIZE) && (r.win_height >= MIN_SIZE) &&
           (r.win_width[3:0] == 4'd0) && (r.win_height[3:0] == 4'd0) &&
           (r.win_width <= cw) && (r.win_height <= ch) &&
           (({1'b0, r.win_x} + {1'b0, r.win_width}) <= {1'b0, cw}) &&
           (({1'b0, r.win_y} + {1'b0, r.win_height}) <= {1'b0, ch}) &&
           (r.inner_x <= r.win_width[11:1]) && (r.inner_y <= r.win_height[11:1]) &&
           (r.outer_x <= cw) && (r.outer_y <= ch);
    return good;
  endfunction

  function automatic logic signed [WIDE_W-1:0] clamp_s(input logic signed [WIDE_W-1:0] v,
                                                      input logic signed [WIDE_W-1:0] lo,
                                                      input logic signed [WIDE_W-1:0] hi);
    logic signed [WIDE_W-1:0] q;
    q = v;
    if (v < lo) q = lo;
    else if (v > hi) q = hi;
    return q;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/vwce_in_if.sv -----
// Input channel interface carrying button update and begin request beats.
`default_nettype none

interface vwce_in_if;
  import vwce_pkg::*;
  logic valid;
  logic ready;
  logic op;
  logic [BTN_W-1:0] held_buttons;
  logic [BTN_W-1:0] new_presses;
  modport source(output valid, op, held_buttons, new_presses, input ready);
  modport sink(input valid, op, held_buttons, new_presses, output ready);
endinterface

`default_nettype wire

// ----- hdl/vwce_out_if.sv -----
// Result channel interface carrying the status and window of each step.
`default_nettype none

interface vwce_out_if;
  import vwce_pkg::*;
  logic valid;
  logic ready;
  logic ok;
  logic [1:0] event_res;
  logic [1:0] mode;
  logic owns_foreground;
  logic [COORD_W-1:0] win_x;
  logic [COORD_W-1:0] win_y;
  logic [COORD_W-1:0] win_width;
  logic [COORD_W-1:0] win_height;
  logic [MATTE_W-1:0] inner_x;
  logic [MATTE_W-1:0] inner_y;
  logic [COORD_W-1:0] outer_x;
  logic [COORD_W-1:0] outer_y;
  modport source(output valid, ok, event_res, mode, owns_foreground, win_x, win_y, win_width,
                 win_height, inner_x, inner_y, outer_x, outer_y, input ready);
  modport sink(input valid, ok, event_res, mode, owns_foreground, win_x, win_y, win_width,
               win_height, inner_x, inner_y, outer_x, outer_y, output ready);
endinterface

`default_nettype wire

// ----- hdl/vwce_cfg_if.sv -----
// Configuration write channel interface carrying a register address and data.
`default_nettype none

interface vwce_cfg_if;
  import vwce_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CANVAS_W-1:0] data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/vwce_region_edit.sv -----
// Nudge, resize, inner and outer offset and canvas clamp logic for the working window.
`default_nettype none

module vwce_region_edit (
  input  vwce_pkg::region_t              cur,
  input  logic [vwce_pkg::BTN_W-1:0]     held,
  input  logic [vwce_pkg::CANVAS_W-1:0]  cw,
  input  logic [vwce_pkg::CANVAS_W-1:0]  ch,
  output vwce_pkg::region_t              nxt
);
  import vwce_pkg::*;

  logic signed [WIDE_W-1:0] hz, vt, hv;
  logic signed [WIDE_W-1:0] x, y, w, h, ix, iy, ox, oy;
  logic signed [WIDE_W-1:0] c2x, c2y, nw, nh, dx, dy;
  logic signed [WIDE_W-1:0] wmax, hmax, cws, chs;
  logic signed [WIDE_W-1:0] fw, fh, fx, fy, fix, fiy, fox, foy;

  always_comb begin
    hz = $signed({14'd0, held[BTN_RIGHT]}) - $signed({14'd0, held[BTN_LEFT]});
    vt = $signed({14'd0, held[BTN_DOWN]}) - $signed({14'd0, held[BTN_UP]});
    hv = hz + vt;
    cws = $signed({3'b000, cw});
    chs = $signed({3'b000, ch});
    wmax = $signed({3'b000, cw[11:4], 4'b0000});
    hmax = $signed({3'b000, ch[11:4], 4'b0000});
    x = $signed({3'b000, cur.win_x});
    y = $signed({3'b000, cur.win_y});
    w = $signed({3'b000, cur.win_width});
    h = $signed({3'b000, cur.win_height});
    ix = $signed({4'b0000, cur.inner_x});
    iy = $signed({4'b0000, cur.inner_y});
    ox = $signed({3'b000, cur.outer_x});
    oy = $signed({3'b000, cur.outer_y});
    c2x = (x <<< 1) + w;
    c2y = (y <<< 1) + h;
    nw = clamp_s(w + (hz <<< 4), MIN_SIZE_S, wmax);
    nh = clamp_s(h - (vt <<< 4), MIN_SIZE_S, hmax);
    dx = c2x - nw;
    dy = c2y - nh;

    if (held[BTN_MOVE]) begin
      x = x + hz;
      y = y + vt;
    end else if (held[BTN_INNER]) begin
      ix = ix + hz;
      iy = iy + hv;
    end else if (held[BTN_OUTER]) begin
      ox = ox - hz;
      oy = oy - hv;
    end else begin
      if (hz != '0) begin
        w = nw;
        x = dx >>> 1;
      end
      if (vt != '0) begin
        h = nh;
        y = dy >>> 1;
      end
    end

    fw = clamp_s(w, MIN_SIZE_S, wmax);
    fh = clamp_s(h, MIN_SIZE_S, hmax);
    fx = clamp_s(x, '0, cws - fw);
    fy = clamp_s(y, '0, chs - fh);
    fix = clamp_s(ix, '0, fw >>> 1);
    fiy = clamp_s(iy, '0, fh >>> 1);
    fox = clamp_s(ox, '0, cws);
    foy = clamp_s(oy, '0, chs);

    nxt.win_x = fx[COORD_W-1:0];
    nxt.win_y = fy[COORD_W-1:0];
    nxt.win_width = {fw[COORD_W-1:4], 4'b0000};
    nxt.win_height = {fh[COORD_W-1:4], 4'b0000};
    nxt.inner_x = fix[MATTE_W-1:0];
    nxt.inner_y = fiy[MATTE_W-1:0];
    nxt.outer_x = fox[COORD_W-1:0];
    nxt.outer_y = foy[COORD_W-1:0];
  end

endmodule

`default_nettype wire

// ----- hdl/vwce_ctrl.sv -----
// Mode state machine, canvas registers and working and saved window registers.
`default_nettype none

module vwce_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  vwce_pkg::in_item_t               item,
  input  logic                             cfg_we,
  input  logic [vwce_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [vwce_pkg::CANVAS_W-1:0]    cfg_data,
  output vwce_pkg::out_item_t              res
);
  import vwce_pkg::*;

  mode_t mode_r, mode_nxt;
  logic rp_r, rp_nxt;
  logic armed_r, armed_nxt;
  logic has_saved_r, has_saved_nxt;
  region_t work_r, work_nxt;
  region_t saved_r, saved_nxt;
  logic [CANVAS_W-1:0] cw_r, cw_nxt;
  logic [CANVAS_W-1:0] ch_r, ch_nxt;

  logic cfg_hit;
  logic [CANVAS_W-1:0] cfg_sat;
  logic [CANVAS_W-1:0] cw_sel, ch_sel;
  region_t dflt, restore, edited;
  logic edited_ok, work_ok, armed_rev, ok;
  event_t ev;

  vwce_region_edit u_edit (
    .cur  (work_r),
    .held (item.held_buttons),
    .cw   (cw_r),
    .ch   (ch_r),
    .nxt  (edited)
  );

  always_comb begin
    cfg_hit = cfg_we && ((cfg_addr == CFG_CANVAS_WIDTH) || (cfg_addr == CFG_CANVAS_HEIGHT));
    cfg_sat = cfg_data;
    if (cfg_data < MIN_CANVAS) cfg_sat = MIN_CANVAS;
    else if (cfg_data > MAX_CANVAS) cfg_sat = MAX_CANVAS;
    cw_sel = (cfg_hit && (cfg_addr == CFG_CANVAS_WIDTH)) ? cfg_sat : cw_r;
    ch_sel = (cfg_hit && (cfg_addr == CFG_CANVAS_HEIGHT)) ? cfg_sat : ch_r;
    dflt = default_region(cw_sel, ch_sel);
    restore = has_saved_r ? saved_r : dflt;
    edited_ok = region_ok(edited, cw_r, ch_r);
    work_ok = region_ok(work_r, cw_r, ch_r);
    armed_rev = armed_r | ~item.held_buttons[BTN_ACCEPT];
  end

  always_comb begin
    mode_nxt = mode_r;
    rp_nxt = rp_r;
    armed_nxt = armed_r;
    has_saved_nxt = has_saved_r;
    work_nxt = work_r;
    saved_nxt = saved_r;
    cw_nxt = cw_r;
    ch_nxt = ch_r;
    ok = 1'b1;
    ev = EV_NONE;
    if (cfg_hit) begin
      cw_nxt = cw_sel;
      ch_nxt = ch_sel;
      mode_nxt = MODE_INACTIVE;
      rp_nxt = 1'b0;
      armed_nxt = 1'b0;
      has_saved_nxt = 1'b0;
      work_nxt = dflt;
    end else if (step) begin
      if (item.op == OP_BEGIN) begin
        if ((mode_r != MODE_INACTIVE) || rp_r) begin
          ok = 1'b0;
        end else begin
          work_nxt = restore;
          armed_nxt = 1'b0;
          mode_nxt = MODE_EDIT;
        end
      end else if ((item.new_presses & ~item.held_buttons) != '0) begin
        ok = 1'b0;
      end else if (rp_r) begin
        if (item.held_buttons == '0) begin
          rp_nxt = 1'b0;
          ev = EV_RELEASED;
        end
      end else begin
        case (mode_r)
          MODE_REVIEW: begin
            armed_nxt = armed_rev;
            if (item.new_presses[BTN_CANCEL]) begin
              mode_nxt = MODE_EDIT;
              armed_nxt = 1'b0;
            end else if (armed_rev && item.new_presses[BTN_ACCEPT]) begin
              if (!work_ok) begin
                ok = 1'b0;
              end else begin
                saved_nxt = work_r;
                has_saved_nxt = 1'b1;
                mode_nxt = MODE_INACTIVE;
                armed_nxt = 1'b0;
                rp_nxt = 1'b1;
                ev = EV_ACCEPTED;
              end
            end
          end
          MODE_EDIT: begin
            if (item.new_presses[BTN_ACCEPT]) begin
              mode_nxt = MODE_REVIEW;
              armed_nxt = 1'b0;
            end else if (item.new_presses[BTN_CANCEL]) begin
              work_nxt = restore;
              mode_nxt = MODE_INACTIVE;
              armed_nxt = 1'b0;
              rp_nxt = 1'b1;
              ev = EV_CANCELLED;
            end else if (item.new_presses[BTN_RESET]) begin
              work_nxt = dflt;
            end else begin
              work_nxt = edited;
              ok = edited_ok;
            end
          end
          default: begin
          end
        endcase
      end
    end
    res.ok = ok;
    res.event_res = ev;
    res.mode = mode_nxt;
    res.owns_foreground = (mode_nxt != MODE_INACTIVE) || rp_nxt;
    res.region = work_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INACTIVE;
      rp_r <= 1'b0;
      armed_r <= 1'b0;
      has_saved_r <= 1'b0;
      cw_r <= CANVAS_W_RESET;
      ch_r <= CANVAS_H_RESET;
      work_r <= default_region(CANVAS_W_RESET, CANVAS_H_RESET);
    end else begin
      mode_r <= mode_nxt;
      rp_r <= rp_nxt;
      armed_r <= armed_nxt;
      has_saved_r <= has_saved_nxt;
      cw_r <= cw_nxt;
      ch_r <= ch_nxt;
      work_r <= work_nxt;
    end
  end

  always_ff @(posedge clk) begin
    saved_r <= saved_nxt;
  end

  a_quarantine_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    rp_r |-> (mode_r == MODE_INACTIVE))
    else $error("release quarantine pending outside inactive mode");

  a_armed_in_review: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (mode_r == MODE_REVIEW))
    else $error("accept armed outside review mode");

  a_width_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (work_r.win_width[3:0] == 4'd0) && (work_r.win_height[3:0] == 4'd0) &&
    (work_r.win_width != '0) && (work_r.win_height != '0))
    else $error("working window size not a nonzero multiple of 16");

  a_accept_saves: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !cfg_hit && (res.event_res == EV_ACCEPTED)) |=>
      (has_saved_r && rp_r && (saved_r == work_r)))
    else $error("accepted region not saved");

  a_saved_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(has_saved_r) |-> ($past(cfg_hit) || !$past(rst_n)))
    else $error("saved region dropped without a canvas write");

endmodule

`default_nettype wire

// ----- hdl/video_window_calibration_editor.sv -----
// Top level of the video window calibration editor with its input and result registers.
//
// The block edits a video window on a canvas from one button sample per beat.
// Input channel in_ch: op selects a per-frame button update or a begin request,
// with the held and newly pressed button masks. Result channel out_ch: one
// result beat per input beat with the ok flag, event, mode, foreground
// ownership and the working window. Configuration channel cfg_ch: address 0
// writes the canvas width and address 1 the height; a write to either address
// reinitializes the editor. The channel is always ready; it must be written only while
// the block is idle, which the block itself does not enforce. An accepted beat is held
// in the input register, where the edit and clamp logic runs and the editor state
// updates; the result is then registered in the output register and shown on out_ch.
// One beat is accepted every cycle while the receiver takes results. When the receiver
// stalls, the result holds in the output register and one more beat waits in the input
// register before in_ch.ready drops. Reset clears both valid flags and sets a 720 by 480
// canvas with a centered default window half the canvas size, down to a multiple of 16.
`default_nettype none

module video_window_calibration_editor (
  input  logic           clk,
  input  logic           rst_n,
  vwce_in_if.sink        in_ch,
  vwce_out_if.source     out_ch,
  vwce_cfg_if.sink       cfg_ch
);
  import vwce_pkg::*;

  logic in_vld_r, in_vld_nxt;
  logic out_vld_r, out_vld_nxt;
  in_item_t item_r;
  out_item_t res_r;
  out_item_t res;
  logic adv, in_fire, cfg_we;

  assign adv = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_we = cfg_ch.valid && cfg_ch.ready;

  vwce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .item     (item_r),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_ch.addr),
    .cfg_data (cfg_ch.data),
    .res      (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_fire) in_vld_nxt = 1'b1;
    else if (adv) in_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (adv) out_vld_nxt = 1'b1;
    else if (out_ch.ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.op <= in_ch.op;
      item_r.held_buttons <= in_ch.held_buttons;
      item_r.new_presses <= in_ch.new_presses;
    end
    if (adv) res_r <= res;
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.ok = res_r.ok;
  assign out_ch.event_res = res_r.event_res;
  assign out_ch.mode = res_r.mode;
  assign out_ch.owns_foreground = res_r.owns_foreground;
  assign out_ch.win_x = res_r.region.win_x;
  assign out_ch.win_y = res_r.region.win_y;
  assign out_ch.win_width = res_r.region.win_width;
  assign out_ch.win_height = res_r.region.win_height;
  assign out_ch.inner_x = res_r.region.inner_x;
  assign out_ch.inner_y = res_r.region.inner_y;
  assign out_ch.outer_x = res_r.region.outer_x;
  assign out_ch.outer_y = res_r.region.outer_y;

endmodule

`default_nettype wire
